// ===== hdl/cqk_pkg.sv =====
// Package: sizes, codes, transaction structs and pointer helper for the circular key queue.
`default_nettype none
package cqk_pkg;

  // Queue geometry
  localparam int unsigned DEPTH = 16;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned OCC_W = 5;
  localparam int unsigned REC_W = 57;

  // Action codes
  localparam logic [1:0] ACT_ENQ    = 2'd0;
  localparam logic [1:0] ACT_ENQ_UQ = 2'd1;
  localparam logic [1:0] ACT_DEQ    = 2'd2;
  localparam logic [1:0] ACT_QUERY  = 2'd3;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_DUP   = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] name_id;
    logic [15:0] species_id;
    logic [15:0] color_key;
    logic        bread_flag;
    logic [7:0]  age;
  } cqk_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [OCC_W-1:0] occupancy;
    logic             front_valid;
    logic [15:0]      front_name;
    logic [15:0]      front_species;
    logic [15:0]      front_color;
    logic             front_bread;
    logic [7:0]       front_age;
  } cqk_rsp_t;

  // Stored record, 57 bits
  typedef struct packed {
    logic [15:0] name;
    logic [15:0] species;
    logic [15:0] color;
    logic        bread;
    logic [7:0]  age;
  } cqk_rec_t;

  // Key compare unit control
  typedef struct packed {
    logic clear;
    logic cmp;
  } cqk_scan_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_READ,
    ST_OUT
  } cqk_state_e;

  // Advance a pointer with wrap at the queue depth
  function automatic logic [PTR_W-1:0] cqk_wrap_next(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] nxt;
    if (ptr == PTR_W'(DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + PTR_W'(1);
    end
    return nxt;
  endfunction

endpackage : cqk_pkg
`default_nettype wire

// ===== hdl/cqk_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none
module cqk_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic                                    re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : cqk_ram
`default_nettype wire

// ===== hdl/cqk_scan.sv =====
// Key compare unit: accumulates a match flag over entries streamed out of the record store.
`default_nettype none
module cqk_scan (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cqk_pkg::cqk_scan_ctl_t ctl_i,
  input  wire logic [15:0]            key_i,
  input  wire logic [15:0]            rd_color_i,
  output logic                        hit_o
);
  import cqk_pkg::*;

  logic hit_d, hit_q;

  // Clear at the start of a transaction, set on any matching entry
  always_comb begin
    hit_d = hit_q;
    if (ctl_i.clear) begin
      hit_d = 1'b0;
    end else if (ctl_i.cmp && (rd_color_i == key_i)) begin
      hit_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign hit_o = hit_q;

endmodule : cqk_scan
`default_nettype wire

// ===== hdl/circular_queue_unique_key_unit.sv =====
// Top level: circular record queue with duplicate key reject, sequencer around one record RAM.
//
//  channel   | handshake          | payload | direction
//  ----------+--------------------+---------+----------
//  request   | start, busy        | req_i   | in
//  result    | valid_o (strobe)   | rsp_o   | out
//
// A transaction is taken when start is high and busy is low. Plain enqueue, dequeue,
// query and unique enqueue on an empty queue step through the apply, read and output states.
// Otherwise unique enqueue first streams every occupied entry through the RAM read port,
// one per cycle, in the scan state before the apply, read and output states.
// Reset empties the queue at once; stored records need no clearing.
// The result strobe lasts one cycle and cannot be held off; busy stays high until then.
`default_nettype none
module circular_queue_unique_key_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire cqk_pkg::cqk_req_t req_i,
  output logic                   valid_o,
  output cqk_pkg::cqk_rsp_t      rsp_o
);
  import cqk_pkg::*;

  cqk_state_e       state_d, state_q;
  logic [PTR_W-1:0] head_d, head_q;
  logic [PTR_W-1:0] tail_d, tail_q;
  logic [CNT_W-1:0] cnt_d, cnt_q;
  logic [PTR_W-1:0] scan_ptr_d, scan_ptr_q;
  logic [CNT_W-1:0] issued_d, issued_q;
  logic             rvalid_d, rvalid_q;
  logic [1:0]       status_d, status_q;
  cqk_req_t         req_d, req_q;

  logic             ram_we;
  logic             ram_re;
  logic [PTR_W-1:0] ram_raddr;
  cqk_rec_t         ram_wdata;
  cqk_rec_t         ram_rdata;
  cqk_scan_ctl_t    scan_ctl;
  logic             hit;
  logic             full;
  logic             empty;

  assign full  = (cnt_q == CNT_W'(DEPTH));
  assign empty = (cnt_q == '0);

  // Record to store, taken from the held request
  assign ram_wdata = '{name:    req_q.name_id,
                       species: req_q.species_id,
                       color:   req_q.color_key,
                       bread:   req_q.bread_flag,
                       age:     req_q.age};

  cqk_ram #(
    .WIDTH (REC_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cqk_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (scan_ctl),
    .key_i      (req_q.color_key),
    .rd_color_i (ram_rdata.color),
    .hit_o      (hit)
  );

  // Sequencer: next state, pointer updates and RAM control
  always_comb begin
    state_d        = state_q;
    head_d         = head_q;
    tail_d         = tail_q;
    cnt_d          = cnt_q;
    scan_ptr_d     = scan_ptr_q;
    issued_d       = issued_q;
    rvalid_d       = 1'b0;
    status_d       = status_q;
    req_d          = req_q;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = head_q;
    scan_ctl.clear = 1'b0;
    scan_ctl.cmp   = 1'b0;
    valid_o        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          req_d          = req_i;
          scan_ctl.clear = 1'b1;
          scan_ptr_d     = head_q;
          issued_d       = '0;
          if ((req_i.action == ACT_ENQ_UQ) && !empty) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_APPLY;
          end
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle, compare the data that returns
        scan_ctl.cmp = rvalid_q;
        ram_raddr    = scan_ptr_q;
        if (issued_q != cnt_q) begin
          ram_re     = 1'b1;
          rvalid_d   = 1'b1;
          scan_ptr_d = cqk_wrap_next(scan_ptr_q);
          issued_d   = issued_q + CNT_W'(1);
        end else begin
          state_d = ST_APPLY;
        end
      end

      ST_APPLY: begin
        state_d = ST_READ;
        unique case (req_q.action)
          ACT_ENQ, ACT_ENQ_UQ: begin
            if ((req_q.action == ACT_ENQ_UQ) && hit) begin
              status_d = STAT_DUP;
            end else if (full) begin
              status_d = STAT_FULL;
            end else begin
              status_d = STAT_OK;
              ram_we   = 1'b1;
              tail_d   = cqk_wrap_next(tail_q);
              cnt_d    = cnt_q + CNT_W'(1);
            end
          end
          ACT_DEQ: begin
            if (empty) begin
              status_d = STAT_EMPTY;
            end else begin
              status_d = STAT_OK;
              head_d   = cqk_wrap_next(head_q);
              cnt_d    = cnt_q - CNT_W'(1);
            end
          end
          ACT_QUERY: begin
            status_d = STAT_OK;
          end
          default: begin
            status_d = STAT_OK;
          end
        endcase
      end

      ST_READ: begin
        // Fetch the head record for the result
        ram_re  = 1'b1;
        state_d = ST_OUT;
      end

      ST_OUT: begin
        valid_o = 1'b1;
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_q     <= '0;
      tail_q     <= '0;
      cnt_q      <= '0;
      scan_ptr_q <= '0;
      issued_q   <= '0;
      rvalid_q   <= 1'b0;
      status_q   <= STAT_OK;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      cnt_q      <= cnt_d;
      scan_ptr_q <= scan_ptr_d;
      issued_q   <= issued_d;
      rvalid_q   <= rvalid_d;
      status_q   <= status_d;
    end
  end

  // Held request payload
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  assign busy = (state_q != ST_IDLE);

  // Result: zero front fields on an empty queue
  always_comb begin
    rsp_o.status        = status_q;
    rsp_o.occupancy     = OCC_W'(cnt_q);
    rsp_o.front_valid   = !empty;
    rsp_o.front_name    = empty ? '0 : ram_rdata.name;
    rsp_o.front_species = empty ? '0 : ram_rdata.species;
    rsp_o.front_color   = empty ? '0 : ram_rdata.color;
    rsp_o.front_bread   = empty ? 1'b0 : ram_rdata.bread;
    rsp_o.front_age     = empty ? '0 : ram_rdata.age;
  end

endmodule : circular_queue_unique_key_unit
`default_nettype wire
